// ===== hw/rtl/cpustep_pkg.sv =====
// Shared opcodes, register indexes and controller/datapath interface types of the CPU step unit.
package cpustep_pkg;

    // Default memory depth in words
    localparam int MEM_WORDS_DEFAULT = 65536;

    // Item commands
    localparam logic CMD_EXEC = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Opcodes
    localparam logic [3:0] OP_MOVL = 4'b0000;
    localparam logic [3:0] OP_SETH = 4'b0001;
    localparam logic [3:0] OP_STR  = 4'b0100;
    localparam logic [3:0] OP_LDR  = 4'b0101;
    localparam logic [3:0] OP_ADD  = 4'b1000;
    localparam logic [3:0] OP_SUB  = 4'b1001;
    localparam logic [3:0] OP_AND  = 4'b1010;
    localparam logic [3:0] OP_ORR  = 4'b1011;

    // Special register indexes
    localparam logic [2:0] REG_ZERO = 3'd0;
    localparam logic [2:0] REG_FL   = 3'd5;
    localparam logic [2:0] REG_BAD  = 3'd6;
    localparam logic [2:0] REG_PC   = 3'd7;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // latch the item and its first memory address
        logic clear;    // write one zero word of the clearing pass
        logic decode;   // latch the instruction and read its operands
        logic exec;     // form the data address of str or ldr
        logic commit;   // update state and load the output register
    } cs_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last; // clearing pass is at the last word
        logic mem_op;     // latched instruction is an executed str or ldr
    } cs_status_t;

endpackage

// ===== hw/rtl/cpustep_dp.sv =====
// Datapath of the CPU step unit: registers, flags, word memory, ALU and output register.
module cpustep_dp
    import cpustep_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cs_cmd_t     ctl,
    output cs_status_t  sts,
    input  logic        cmd,
    input  logic [15:0] load_address,
    input  logic [15:0] load_data,
    output logic [15:0] pc_after,
    output logic [15:0] fetched_word,
    output logic        executed,
    output logic        reg_write,
    output logic [2:0]  reg_index,
    output logic [15:0] reg_value,
    output logic [3:0]  flag_bits,
    output logic        mem_write,
    output logic [15:0] mem_address,
    output logic [15:0] mem_value
);

    localparam int          AW        = $clog2(MEM_WORDS);
    localparam logic [23:0] MEM_W24   = 24'(MEM_WORDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_WORDS - 1);

    // Reduce a word address modulo the depth: quotient stays below 256
    function automatic logic [AW-1:0] wrap_addr(input logic [15:0] a);
        logic [23:0] r;
        r = {8'd0, a};
        for (int k = 7; k >= 0; k--)
        begin
            if (r >= (MEM_W24 << k))
                r = r - (MEM_W24 << k);
        end
        return r[AW-1:0];
    endfunction

    // Decide whether an instruction takes effect
    function automatic logic exec_ok_f(input logic [15:0] w, input logic z);
        logic [3:0] op;
        logic [2:0] rd;
        logic [2:0] ra;
        logic [2:0] rb;
        logic       defined;
        logic       bad6;
        op = w[15:12];
        rd = w[10:8];
        ra = w[6:4];
        rb = w[2:0];
        defined = (op == OP_MOVL) || (op == OP_SETH) || (op == OP_STR) || (op == OP_LDR) ||
                  (op == OP_ADD) || (op == OP_SUB) || (op == OP_AND) || (op == OP_ORR);
        if ((op == OP_MOVL) || (op == OP_SETH))
            bad6 = (rd == REG_BAD);
        else if ((op == OP_STR) || (op == OP_LDR))
            bad6 = (rd == REG_BAD) || (ra == REG_BAD);
        else
            bad6 = (rd == REG_BAD) || (ra == REG_BAD) || (rb == REG_BAD);
        return defined && !bad6 && !(w[11] && !z);
    endfunction

    // Architectural state
    logic [15:0] gpr_reg [8];
    logic [15:0] pc_reg;
    logic [15:0] fl_reg;
    logic        zflag_reg;
    logic [AW-1:0] clr_cnt_reg;

    // Item and pipeline payload
    logic [AW-1:0] addr_reg;
    logic [15:0] rdata_reg;
    logic [15:0] instr_reg;
    logic        is_load_reg;
    logic [15:0] ldata_reg;
    logic [15:0] opa_reg;
    logic [15:0] opb_reg;
    logic [15:0] mem_array [MEM_WORDS];

    // Output register
    logic [15:0] pc_after_reg;
    logic [15:0] fetched_word_reg;
    logic        executed_reg;
    logic        reg_write_reg;
    logic [2:0]  reg_index_reg;
    logic [15:0] reg_value_reg;
    logic [3:0]  flag_bits_reg;
    logic        mem_write_reg;
    logic [15:0] mem_address_reg;
    logic [15:0] mem_value_reg;

    // Decode fields of the fetched word
    logic [3:0]  d_op;
    logic [2:0]  d_rd;
    logic [2:0]  d_ra;
    logic [2:0]  d_rb;
    logic [2:0]  sel_a;
    logic [2:0]  sel_b;
    logic [15:0] opa_next;
    logic [15:0] opb_next;

    assign d_op  = rdata_reg[15:12];
    assign d_rd  = rdata_reg[10:8];
    assign d_ra  = rdata_reg[6:4];
    assign d_rb  = rdata_reg[2:0];
    assign sel_a = (d_op == OP_SETH) ? d_rd : d_ra;
    assign sel_b = (d_op == OP_STR) ? d_rd : d_rb;

    // Read two register ports; PC reads as already incremented
    always_comb
    begin
        if (sel_a == REG_PC)
            opa_next = pc_reg + 16'd1;
        else if (sel_a == REG_FL)
            opa_next = fl_reg;
        else
            opa_next = gpr_reg[sel_a];
        if (sel_b == REG_PC)
            opb_next = pc_reg + 16'd1;
        else if (sel_b == REG_FL)
            opb_next = fl_reg;
        else
            opb_next = gpr_reg[sel_b];
    end

    // Execute fields of the latched instruction
    logic [3:0]  e_op;
    logic [2:0]  e_rd;
    logic [7:0]  e_imm;
    logic        e_ok;
    logic [16:0] sum17;
    logic [16:0] dif17;
    logic [15:0] res;
    logic        wr;
    logic        alu;
    logic        c_bit;
    logic        v_bit;
    logic [3:0]  flags4;
    logic        c_rwr;
    logic        c_str;
    logic        c_mw;
    logic        c_alu;
    logic [15:0] pc_next;
    logic [15:0] fl_next;
    logic        zflag_next;

    assign e_op  = instr_reg[15:12];
    assign e_rd  = instr_reg[10:8];
    assign e_imm = instr_reg[7:0];
    assign e_ok  = exec_ok_f(instr_reg, zflag_reg);
    assign sum17 = {1'b0, opa_reg} + {1'b0, opb_reg};
    assign dif17 = {1'b0, opa_reg} - {1'b0, opb_reg};

    // Form the result and flags of the instruction
    always_comb
    begin
        res   = '0;
        wr    = 1'b0;
        alu   = 1'b0;
        c_bit = 1'b0;
        v_bit = 1'b0;
        unique case (e_op)
            OP_MOVL:
            begin
                res = {8'd0, e_imm};
                wr  = 1'b1;
            end
            OP_SETH:
            begin
                res = {e_imm, opa_reg[7:0]};
                wr  = 1'b1;
            end
            OP_LDR:
            begin
                res = rdata_reg;
                wr  = 1'b1;
            end
            OP_ADD:
            begin
                res   = sum17[15:0];
                wr    = 1'b1;
                alu   = 1'b1;
                c_bit = sum17[16];
                v_bit = (opa_reg[15] == opb_reg[15]) && (sum17[15] != opa_reg[15]);
            end
            OP_SUB:
            begin
                res   = dif17[15:0];
                wr    = 1'b1;
                alu   = 1'b1;
                c_bit = dif17[16];
                v_bit = (opa_reg[15] != opb_reg[15]) && (dif17[15] != opa_reg[15]);
            end
            OP_AND:
            begin
                res = opa_reg & opb_reg;
                wr  = 1'b1;
                alu = 1'b1;
            end
            OP_ORR:
            begin
                res = opa_reg | opb_reg;
                wr  = 1'b1;
                alu = 1'b1;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    assign flags4 = {v_bit, c_bit, res[15], (res == 16'd0)};
    assign c_rwr  = !is_load_reg && e_ok && wr && (e_rd != REG_ZERO);
    assign c_str  = !is_load_reg && e_ok && (e_op == OP_STR);
    assign c_mw   = is_load_reg || c_str;
    assign c_alu  = !is_load_reg && e_ok && alu;

    // Next PC, FL and zero flag at commit
    always_comb
    begin
        if (is_load_reg)
            pc_next = pc_reg;
        else if (c_rwr && (e_rd == REG_PC))
            pc_next = res;
        else
            pc_next = pc_reg + 16'd1;
        if (c_alu)
            fl_next = {12'd0, flags4};
        else if (c_rwr && (e_rd == REG_FL))
            fl_next = res;
        else
            fl_next = fl_reg;
        zflag_next = c_alu ? flags4[0] : zflag_reg;
    end

    assign sts.clear_last = (clr_cnt_reg == LAST_ADDR);
    assign sts.mem_op     = e_ok && ((e_op == OP_STR) || (e_op == OP_LDR));

    // Update architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                gpr_reg[i] <= '0;
            pc_reg      <= '0;
            fl_reg      <= '0;
            zflag_reg   <= 1'b0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (ctl.clear)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (ctl.commit)
            begin
                pc_reg    <= pc_next;
                fl_reg    <= fl_next;
                zflag_reg <= zflag_next;
                if (c_rwr && (e_rd != REG_PC) && (e_rd != REG_FL))
                    gpr_reg[e_rd] <= res;
            end
        end
    end

    // Share one address reducer between fetch, load and data access
    logic [15:0]   wrap_in;
    logic [AW-1:0] addr_next;

    assign wrap_in   = ctl.accept ? ((cmd == CMD_LOAD) ? load_address : pc_reg) : opa_reg;
    assign addr_next = wrap_addr(wrap_in);

    // Latch item, instruction and operands
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            is_load_reg <= (cmd == CMD_LOAD);
            ldata_reg   <= load_data;
        end
        if (ctl.accept || ctl.exec)
            addr_reg <= addr_next;
        if (ctl.decode)
        begin
            instr_reg <= rdata_reg;
            opa_reg   <= opa_next;
            opb_reg   <= opb_next;
        end
    end

    // Word memory: one write port, one registered read port
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;

    assign mem_we    = ctl.clear || (ctl.commit && c_mw);
    assign mem_waddr = ctl.clear ? clr_cnt_reg : addr_reg;
    assign mem_wdata = ctl.clear ? 16'd0 : (is_load_reg ? ldata_reg : opb_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem_array[mem_waddr] <= mem_wdata;
        rdata_reg <= mem_array[addr_reg];
    end

    // Load the output register at commit
    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            pc_after_reg     <= pc_next;
            fetched_word_reg <= is_load_reg ? 16'd0 : instr_reg;
            executed_reg     <= !is_load_reg && e_ok;
            reg_write_reg    <= c_rwr;
            reg_index_reg    <= c_rwr ? e_rd : 3'd0;
            reg_value_reg    <= c_rwr ? res : 16'd0;
            flag_bits_reg    <= fl_next[3:0];
            mem_write_reg    <= c_mw;
            mem_address_reg  <= c_mw ? 16'(addr_reg) : 16'd0;
            mem_value_reg    <= c_mw ? mem_wdata : 16'd0;
        end
    end

    assign pc_after     = pc_after_reg;
    assign fetched_word = fetched_word_reg;
    assign executed     = executed_reg;
    assign reg_write    = reg_write_reg;
    assign reg_index    = reg_index_reg;
    assign reg_value    = reg_value_reg;
    assign flag_bits    = flag_bits_reg;
    assign mem_write    = mem_write_reg;
    assign mem_address  = mem_address_reg;
    assign mem_value    = mem_value_reg;

`ifndef NO_ASSERTIONS
    // Memory writes stay inside the configured depth
    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (32'(mem_waddr) < 32'(MEM_WORDS)))
        else $error("memory write beyond depth");

    // PC moves only when an item commits
    a_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.commit |=> $stable(pc_reg))
        else $error("PC changed without commit");

    // An executed ALU op leaves the zero flag equal to FL bit Z
    a_zflag_fl: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.commit && c_alu) |=> (zflag_reg == fl_reg[0]))
        else $error("zero flag and FL disagree");
`endif

endmodule

// ===== hw/rtl/cpustep_ctrl.sv =====
// Controller of the CPU step unit: clearing pass, item sequencing and output handshake.
module cpustep_ctrl
    import cpustep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    output logic       out_valid,
    input  logic       out_ready,
    input  cs_status_t sts,
    output cs_cmd_t    ctl
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_FETCH  = 7'b0000100,
        S_DECODE = 7'b0001000,
        S_EXEC   = 7'b0010000,
        S_MEM    = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    // Sequence one item at a time
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clear = 1'b1;
                if (sts.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.accept = 1'b1;
                    state_next = (cmd == CMD_LOAD) ? S_FINISH : S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_DECODE;
            end
            S_DECODE:
            begin
                ctl.decode = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (sts.mem_op)
                begin
                    ctl.exec   = 1'b1;
                    state_next = S_MEM;
                end
                else if (out_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MEM:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result until taken
    always_comb
    begin
        if (ctl.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    // An accepted item closes the input until it commits
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while busy");

    // A commit always presents a result
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> out_valid)
        else $error("commit without result");

    // Commit never overwrites a waiting result
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten");
`endif

endmodule

// ===== hw/rtl/sixteen_bit_cpu_step_unit.sv =====
// Top level of the 16-bit CPU step unit: controller and datapath.
// Path from acceptance to result: a load item goes straight to the finish state; movl, seth,
// ALU ops and skipped instructions pass fetch, decode and execute; executed str and ldr also
// pass memory and finish; set by the registered memory read port and registered operand reads.
// Throughput: one item at a time; the next item is taken the cycle after commit.
// Reset clears registers and flags, then a clearing pass zeroes every memory word.
module sixteen_bit_cpu_step_unit
    import cpustep_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [15:0] load_address,
    input  logic [15:0] load_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] pc_after,
    output logic [15:0] fetched_word,
    output logic        executed,
    output logic        reg_write,
    output logic [2:0]  reg_index,
    output logic [15:0] reg_value,
    output logic [3:0]  flag_bits,
    output logic        mem_write,
    output logic [15:0] mem_address,
    output logic [15:0] mem_value
);

    cs_cmd_t    ctl;
    cs_status_t sts;

    // Sequence items
    cpustep_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Hold state and compute results
    cpustep_dp #(
        .MEM_WORDS (MEM_WORDS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .cmd          (cmd),
        .load_address (load_address),
        .load_data    (load_data),
        .pc_after     (pc_after),
        .fetched_word (fetched_word),
        .executed     (executed),
        .reg_write    (reg_write),
        .reg_index    (reg_index),
        .reg_value    (reg_value),
        .flag_bits    (flag_bits),
        .mem_write    (mem_write),
        .mem_address  (mem_address),
        .mem_value    (mem_value)
    );

endmodule

// ===== test/tb_sixteen_bit_cpu_step_unit.sv =====
// Testbench for the 16-bit CPU step unit: directed program table, random programs, scoreboard.
`timescale 1ns / 100ps

module tb_sixteen_bit_cpu_step_unit
    import cpustep_pkg::*;
();

    localparam int MEM_DEPTH    = MEM_WORDS_DEFAULT;
    localparam int RANDOM_ITEMS = 950;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int DIR_ROWS     = 26;

    // Opcode with no defined behavior, used to probe the decoder
    localparam logic [3:0] OP_UNDEF = 4'b0010;

    typedef struct packed {
        logic [15:0] pc_after;
        logic [15:0] fetched_word;
        logic        executed;
        logic        reg_write;
        logic [2:0]  reg_index;
        logic [15:0] reg_value;
        logic [3:0]  flag_bits;
        logic        mem_write;
        logic [15:0] mem_address;
        logic [15:0] mem_value;
    } step_result_t;

    typedef struct packed {
        logic         cmd;
        logic [15:0]  address;
        logic [15:0]  data;
        logic         typed;
        step_result_t want;
    } step_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        cmd = 1'b0;
    logic [15:0] load_address = 16'h0000;
    logic [15:0] load_data = 16'h0000;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] pc_after;
    logic [15:0] fetched_word;
    logic        executed;
    logic        reg_write;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic [3:0]  flag_bits;
    logic        mem_write;
    logic [15:0] mem_address;
    logic [15:0] mem_value;

    // Shadow CPU state
    bit [15:0] cpu_regs [8];
    bit        cpu_zero;
    bit [15:0] cpu_mem [MEM_DEPTH];

    step_result_t expected_steps [$];
    step_row_t    step_table [DIR_ROWS];

    bit calm = 1'b0;
    int mismatches = 0;
    int results_seen = 0;
    int load_items = 0;
    int exec_items = 0;
    int skipped_steps = 0;
    int cycle_count = 0;

    sixteen_bit_cpu_step_unit #(.MEM_WORDS(MEM_DEPTH)) dut (.*);

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [15:0] word_addr(input logic [15:0] a);
        return 16'(int'(a) % MEM_DEPTH);
    endfunction

    function automatic logic [15:0] insn_imm(input logic [3:0] op, input logic zb,
                                             input logic [2:0] rd, input logic [7:0] imm);
        return {op, zb, rd, imm};
    endfunction

    function automatic logic [15:0] insn_reg(input logic [3:0] op, input logic zb,
                                             input logic [2:0] rd, input logic [2:0] ra,
                                             input logic [2:0] rb);
        return {op, zb, rd, 1'b0, ra, 1'b0, rb};
    endfunction

    // Random defined instruction; register six is mostly steered away from
    function automatic logic [15:0] random_insn();
        logic [15:0] w;
        logic [3:0]  op;
        case ($urandom_range(7))
            0: op = OP_MOVL;
            1: op = OP_SETH;
            2: op = OP_STR;
            3: op = OP_LDR;
            4: op = OP_ADD;
            5: op = OP_SUB;
            6: op = OP_AND;
            default: op = OP_ORR;
        endcase
        w = {op, 12'($urandom)};
        w[11] = ($urandom_range(99) < 25);
        if ($urandom_range(99) < 70)
        begin
            if (w[10:8] == REG_BAD) w[10:8] = 3'd1;
            if (w[6:4] == REG_BAD) w[6:4] = 3'd2;
            if (w[2:0] == REG_BAD) w[2:0] = 3'd3;
        end
        return w;
    endfunction

    // Advance the shadow CPU by one item and form its result
    task automatic predict_step(input logic c, input logic [15:0] la, input logic [15:0] ld,
                                output step_result_t r);
        logic [15:0] pc, w, a, b, res, addr;
        logic [16:0] sum;
        logic [3:0]  op;
        logic [2:0]  rd, ra, rb;
        logic        zb, cf, vf;
        bit          known, bad6, wr, alu;
        r = '0;
        if (c == CMD_LOAD)
        begin
            addr = word_addr(la);
            cpu_mem[addr] = ld;
            r.mem_write = 1'b1;
            r.mem_address = addr;
            r.mem_value = ld;
            load_items++;
        end
        else
        begin
            exec_items++;
            pc = cpu_regs[REG_PC];
            w = cpu_mem[word_addr(pc)];
            op = w[15:12];
            zb = w[11];
            rd = w[10:8];
            ra = w[6:4];
            rb = w[2:0];
            r.fetched_word = w;
            cpu_regs[REG_PC] = pc + 16'd1;

            // Register six only counts in the fields that the format uses
            known = 1'b1;
            bad6 = 1'b0;
            case (op)
                OP_MOVL, OP_SETH: bad6 = (rd == REG_BAD);
                OP_STR, OP_LDR: bad6 = (rd == REG_BAD) || (ra == REG_BAD);
                OP_ADD, OP_SUB, OP_AND, OP_ORR:
                    bad6 = (rd == REG_BAD) || (ra == REG_BAD) || (rb == REG_BAD);
                default: known = 1'b0;
            endcase

            if (known && !bad6 && !(zb && !cpu_zero))
            begin
                r.executed = 1'b1;
                wr = 1'b0;
                alu = 1'b0;
                res = 16'h0000;
                cf = 1'b0;
                vf = 1'b0;
                a = cpu_regs[ra];
                b = cpu_regs[rb];
                case (op)
                    OP_MOVL:
                    begin
                        res = {8'h00, w[7:0]};
                        wr = 1'b1;
                    end
                    OP_SETH:
                    begin
                        res = {w[7:0], cpu_regs[rd][7:0]};
                        wr = 1'b1;
                    end
                    OP_STR:
                    begin
                        addr = word_addr(a);
                        cpu_mem[addr] = cpu_regs[rd];
                        r.mem_write = 1'b1;
                        r.mem_address = addr;
                        r.mem_value = cpu_regs[rd];
                    end
                    OP_LDR:
                    begin
                        res = cpu_mem[word_addr(a)];
                        wr = 1'b1;
                    end
                    OP_ADD:
                    begin
                        sum = {1'b0, a} + {1'b0, b};
                        res = sum[15:0];
                        cf = sum[16];
                        vf = ~(a[15] ^ b[15]) & (a[15] ^ res[15]);
                        wr = 1'b1;
                        alu = 1'b1;
                    end
                    OP_SUB:
                    begin
                        res = a - b;
                        cf = (a < b);
                        vf = (a[15] ^ b[15]) & (a[15] ^ res[15]);
                        wr = 1'b1;
                        alu = 1'b1;
                    end
                    OP_AND:
                    begin
                        res = a & b;
                        wr = 1'b1;
                        alu = 1'b1;
                    end
                    default:
                    begin
                        res = a | b;
                        wr = 1'b1;
                        alu = 1'b1;
                    end
                endcase

                // Drop writes to register zero; flags land after the write
                if (wr && rd != REG_ZERO)
                begin
                    cpu_regs[rd] = res;
                    r.reg_write = 1'b1;
                    r.reg_index = rd;
                    r.reg_value = res;
                end
                if (alu)
                begin
                    cpu_zero = (res == 16'h0000);
                    cpu_regs[REG_FL] = {12'h000, vf, cf, res[15], res == 16'h0000};
                end
            end
            else
                skipped_steps++;
        end
        r.pc_after = cpu_regs[REG_PC];
        r.flag_bits = cpu_regs[REG_FL][3:0];
    endtask

    // Offer one item, hold it until taken, then record its expected result
    task automatic send_item(input logic c, input logic [15:0] a, input logic [15:0] d);
        step_result_t r;
        if (!calm && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 17);
        end
        in_valid <= 1'b1;
        cmd <= c;
        load_address <= a;
        load_data <= d;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_step(c, a, d, r);
        expected_steps.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Stall the result side at random
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 17);

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        step_result_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {pc_after, fetched_word, executed, reg_write, reg_index, reg_value,
                   flag_bits, mem_write, mem_address, mem_value};
            if (expected_steps.size() == 0)
                report_mismatch("result with nothing pending", 16'd1, 16'd0);
            else
            begin
                want = expected_steps.pop_front();
                results_seen++;
                if (got.pc_after !== want.pc_after)
                    report_mismatch("pc_after", got.pc_after, want.pc_after);
                if (got.fetched_word !== want.fetched_word)
                    report_mismatch("fetched_word", got.fetched_word, want.fetched_word);
                if (got.executed !== want.executed)
                    report_mismatch("executed", 16'(got.executed), 16'(want.executed));
                if (got.reg_write !== want.reg_write)
                    report_mismatch("reg_write", 16'(got.reg_write), 16'(want.reg_write));
                if (got.reg_index !== want.reg_index)
                    report_mismatch("reg_index", 16'(got.reg_index), 16'(want.reg_index));
                if (got.reg_value !== want.reg_value)
                    report_mismatch("reg_value", got.reg_value, want.reg_value);
                if (got.flag_bits !== want.flag_bits)
                    report_mismatch("flag_bits", 16'(got.flag_bits), 16'(want.flag_bits));
                if (got.mem_write !== want.mem_write)
                    report_mismatch("mem_write", 16'(got.mem_write), 16'(want.mem_write));
                if (got.mem_address !== want.mem_address)
                    report_mismatch("mem_address", got.mem_address, want.mem_address);
                if (got.mem_value !== want.mem_value)
                    report_mismatch("mem_value", got.mem_value, want.mem_value);
            end
        end
    end

    // Watchdog, sized for the memory clearing pass plus a slow run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_sixteen_bit_cpu_step_unit: errors");
            $finish;
        end
    end

    initial
    begin
        int          pick;
        int          sent;
        logic [7:0]  k;

        // Program at 1..12: build extreme operands, run every op, then the corner cases
        step_table = '{
            '{CMD_EXEC, 16'h0000, 16'h0000, 1'b1,
              '{16'd1, 16'h0000, 1'b1, 1'b0, 3'd0, 16'h0000, 4'h0, 1'b0, 16'h0000, 16'h0000}},
            '{CMD_LOAD, 16'hFFFF, 16'hFFFF, 1'b1,
              '{16'd1, 16'h0000, 1'b0, 1'b0, 3'd0, 16'h0000, 4'h0, 1'b1, 16'hFFFF, 16'hFFFF}},
            '{CMD_LOAD, 16'd1, insn_imm(OP_MOVL, 1'b0, 3'd1, 8'hFF), 1'b0, '0},
            '{CMD_LOAD, 16'd2, insn_imm(OP_SETH, 1'b0, 3'd1, 8'h7F), 1'b0, '0},
            '{CMD_LOAD, 16'd3, insn_imm(OP_MOVL, 1'b0, 3'd2, 8'h01), 1'b0, '0},
            '{CMD_LOAD, 16'd4, insn_reg(OP_ADD, 1'b0, 3'd3, 3'd1, 3'd2), 1'b0, '0},
            '{CMD_LOAD, 16'd5, insn_reg(OP_SUB, 1'b0, 3'd4, 3'd2, 3'd1), 1'b0, '0},
            '{CMD_LOAD, 16'd6, insn_reg(OP_ORR, 1'b0, REG_FL, 3'd3, 3'd3), 1'b0, '0},
            '{CMD_LOAD, 16'd7, insn_reg(OP_STR, 1'b0, 3'd1, 3'd2, REG_BAD), 1'b0, '0},
            '{CMD_LOAD, 16'd8, insn_reg(OP_LDR, 1'b0, 3'd3, 3'd2, REG_BAD), 1'b0, '0},
            '{CMD_LOAD, 16'd9, insn_imm(OP_MOVL, 1'b0, REG_BAD, 8'h01), 1'b0, '0},
            '{CMD_LOAD, 16'd10, insn_imm(OP_UNDEF, 1'b0, 3'd1, 8'hFF), 1'b0, '0},
            '{CMD_LOAD, 16'd11, insn_reg(OP_AND, 1'b0, REG_ZERO, 3'd1, REG_ZERO), 1'b0, '0},
            '{CMD_LOAD, 16'd12, insn_imm(OP_MOVL, 1'b1, 3'd2, 8'h55), 1'b0, '0},
            '{CMD_EXEC, 16'hFFFF, 16'h0000, 1'b0, '0},
            '{CMD_EXEC, 16'h0000, 16'hFFFF, 1'b0, '0},
            '{CMD_EXEC, 16'h0000, 16'h0000, 1'b0, '0},
            '{CMD_EXEC, 16'h0000, 16'h0000, 1'b0, '0},
            '{CMD_EXEC, 16'h0000, 16'h0000, 1'b0, '0},
            '{CMD_EXEC, 16'h0000, 16'h0000, 1'b0, '0},
            '{CMD_EXEC, 16'h0000, 16'h0000, 1'b0, '0},
            '{CMD_EXEC, 16'h0000, 16'h0000, 1'b0, '0},
            '{CMD_EXEC, 16'h0000, 16'h0000, 1'b0, '0},
            '{CMD_EXEC, 16'h0000, 16'h0000, 1'b0, '0},
            '{CMD_EXEC, 16'h0000, 16'h0000, 1'b0, '0},
            '{CMD_EXEC, 16'h0000, 16'h0000, 1'b0, '0}
        };

        // Hold reset, then release; the unit clears its memory before taking items
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table; typed rows replace the predicted expectation
        foreach (step_table[i])
        begin
            send_item(step_table[i].cmd, step_table[i].address, step_table[i].data);
            if (step_table[i].typed)
                expected_steps[expected_steps.size() - 1] = step_table[i].want;
        end

        // Random programs: mostly load-at-PC then step, plus jumps and noise
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm = (sent >= 350 && sent < 520);
            pick = $urandom_range(99);
            if (pick < 68)
            begin
                send_item(CMD_LOAD, cpu_regs[REG_PC], random_insn());
                send_item(CMD_EXEC, 16'($urandom), 16'($urandom));
                sent += 2;
            end
            else if (pick < 76)
            begin
                // Jump high in the address space so the PC wraps now and then
                k = ($urandom_range(99) < 30) ? 8'($urandom_range(255, 252)) : 8'($urandom);
                send_item(CMD_LOAD, cpu_regs[REG_PC], insn_imm(OP_MOVL, 1'b0, REG_PC, k));
                send_item(CMD_EXEC, 16'($urandom), 16'($urandom));
                k = ($urandom_range(1) == 1) ? 8'hFF : 8'($urandom);
                send_item(CMD_LOAD, cpu_regs[REG_PC], insn_imm(OP_SETH, 1'b0, REG_PC, k));
                send_item(CMD_EXEC, 16'($urandom), 16'($urandom));
                sent += 4;
            end
            else if (pick < 88)
            begin
                send_item(CMD_LOAD,
                          ($urandom_range(1) == 1) ? 16'($urandom_range(255)) : 16'($urandom),
                          16'($urandom));
                sent += 1;
            end
            else if (pick < 95)
            begin
                send_item(CMD_EXEC, 16'($urandom), 16'($urandom));
                sent += 1;
            end
            else
            begin
                send_item(CMD_LOAD, cpu_regs[REG_PC], 16'($urandom));
                send_item(CMD_EXEC, 16'($urandom), 16'($urandom));
                sent += 2;
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // Drain the remaining results, then allow for stray output
        while (expected_steps.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d memory loads and %0d instruction steps (%0d ran, %0d skipped)",
                 load_items, exec_items, exec_items - skipped_steps, skipped_steps);
        $display("Checked %0d results, %0d field mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("tb_sixteen_bit_cpu_step_unit: clean");
        else
            $display("tb_sixteen_bit_cpu_step_unit: errors");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/cpustep_pkg.sv
hw/rtl/cpustep_dp.sv
hw/rtl/cpustep_ctrl.sv
hw/rtl/sixteen_bit_cpu_step_unit.sv
test/tb_sixteen_bit_cpu_step_unit.sv
